@@ rtl/bso_pkg.sv @@
package bso_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned ROT_W   = 5;
	localparam int unsigned CLR_W   = 6;
	localparam int unsigned FIELD_W = 12;

	// shift type encoding of instruction bits 6..5
	typedef enum logic [1:0] {
		SH_LSL = 2'd0,
		SH_LSR = 2'd1,
		SH_ASR = 2'd2,
		SH_ROR = 2'd3
	} shift_type_t;

	// where the shifter carry comes from
	typedef enum logic [1:0] {
		CSEL_CIN  = 2'd0,
		CSEL_BIT  = 2'd1,
		CSEL_ZERO = 2'd2
	} csel_t;

	// every operand form reduced to: rotate right, then clear n bits at one end and fill
	typedef struct packed {
		logic [WORD_W-1:0] val;
		logic [ROT_W-1:0]  rot;
		logic [CLR_W-1:0]  clr_n;
		logic              clr_hi;
		logic              fill;
		csel_t             csel;
		logic [ROT_W-1:0]  cidx;
		logic              cin;
	} dec_t;

	typedef struct packed {
		logic [WORD_W-1:0] rotated;
		logic [WORD_W-1:0] mask;
		logic              fill;
		logic              carry;
	} rot_t;

endpackage

@@ rtl/bso_req_if.sv @@
interface bso_req_if import bso_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] operand_field;
	logic               imm_form;
	logic               by_register;
	logic [WORD_W-1:0]  reg_value;
	logic [7:0]         shift_reg_byte;
	logic               carry_in;

	modport source (
		output valid, operand_field, imm_form, by_register, reg_value, shift_reg_byte,
		       carry_in,
		input  ready
	);
	modport sink (
		input  valid, operand_field, imm_form, by_register, reg_value, shift_reg_byte,
		       carry_in,
		output ready
	);
endinterface

@@ rtl/bso_rsp_if.sv @@
interface bso_rsp_if import bso_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] operand;
	logic              carry_out;

	modport source (output valid, operand, carry_out, input ready);
	modport sink (input valid, operand, carry_out, output ready);
endinterface

@@ rtl/bso_decode.sv @@
module bso_decode import bso_pkg::*; (
	input  logic [FIELD_W-1:0] operand_field,
	input  logic               imm_form,
	input  logic               by_register,
	input  logic [WORD_W-1:0]  reg_value,
	input  logic [7:0]         shift_reg_byte,
	input  logic               carry_in,
	output dec_t               dec
);

	logic [ROT_W-1:0] a5;
	logic [ROT_W-1:0] imm_rot;
	logic             sign;
	logic             big;
	logic             eq32;
	logic             amt_zero;
	shift_type_t      typ;

	assign typ      = shift_type_t'(operand_field[6:5]);
	assign sign     = reg_value[WORD_W-1];
	assign a5       = by_register ? shift_reg_byte[ROT_W-1:0] : operand_field[11:7];
	assign imm_rot  = {operand_field[11:8], 1'b0};
	assign big      = shift_reg_byte[7:5] != 3'd0;
	assign eq32     = shift_reg_byte == 8'd32;
	assign amt_zero = by_register ? (shift_reg_byte == 8'd0) : (a5 == '0);

	// reduce the operand encoding to rotate / clear / fill / carry select
	always_comb begin
		dec.val    = reg_value;
		dec.rot    = '0;
		dec.clr_n  = '0;
		dec.clr_hi = 1'b1;
		dec.fill   = 1'b0;
		dec.csel   = CSEL_CIN;
		dec.cidx   = '0;
		dec.cin    = carry_in;
		if (imm_form) begin
			dec.val = {{(WORD_W-8){1'b0}}, operand_field[7:0]};
			dec.rot = imm_rot;
			if (imm_rot != '0) begin
				dec.csel = CSEL_BIT;
				dec.cidx = imm_rot - 1'b1;
			end
		end else if (by_register && amt_zero) begin
			// register amount zero: pass value and carry
			dec.csel = CSEL_CIN;
		end else begin
			case (typ)
				SH_LSL: begin
					if (!by_register && amt_zero) begin
						dec.csel = CSEL_CIN;
					end else if (by_register && big) begin
						dec.clr_n = CLR_W'(WORD_W);
						dec.csel  = eq32 ? CSEL_BIT : CSEL_ZERO;
						dec.cidx  = '0;
					end else begin
						dec.rot    = ROT_W'(0) - a5;
						dec.clr_n  = {1'b0, a5};
						dec.clr_hi = 1'b0;
						dec.csel   = CSEL_BIT;
						dec.cidx   = ROT_W'(0) - a5;
					end
				end
				SH_LSR, SH_ASR: begin
					dec.fill = (typ == SH_ASR) ? sign : 1'b0;
					if ((!by_register && amt_zero) || (by_register && big)) begin
						dec.clr_n = CLR_W'(WORD_W);
						dec.csel  = CSEL_BIT;
						dec.cidx  = ROT_W'(WORD_W-1);
						// logical right by more than a word also clears the carry
						if (typ == SH_LSR && by_register && !eq32) begin
							dec.csel = CSEL_ZERO;
						end
					end else begin
						dec.rot   = a5;
						dec.clr_n = {1'b0, a5};
						dec.csel  = CSEL_BIT;
						dec.cidx  = a5 - 1'b1;
					end
				end
				SH_ROR: begin
					dec.csel = CSEL_BIT;
					if (!by_register && amt_zero) begin
						// RRX: rotate by one, old carry into the top bit
						dec.rot   = ROT_W'(1);
						dec.clr_n = CLR_W'(1);
						dec.fill  = carry_in;
						dec.cidx  = '0;
					end else if (a5 == '0) begin
						dec.cidx = ROT_W'(WORD_W-1);
					end else begin
						dec.rot  = a5;
						dec.cidx = a5 - 1'b1;
					end
				end
				default: begin
					dec.csel = CSEL_CIN;
				end
			endcase
		end
	end

endmodule

@@ rtl/barrel_shifter_operand_two.sv @@
// Second-operand barrel shifter for data-processing instructions.
//
// Request channel (req): one beat carries instruction bits 11..0, the
// immediate/register form select, the shift-by-register select, the value
// of Rm (with any PC offset already applied), the low byte of Rs and the
// current C flag. Response channel (rsp): one beat carries the 32-bit
// operand and the shifter carry, in request order.
//
// An accepted request beat passes through three register stages to the
// response beat: decode, rotate, mask and fill. Throughput is one
// beat per cycle; a request is taken in every cycle in which the final
// stage is empty or its beat is being taken.
//
// Reset clears all stage valid bits, so no response appears until a new
// request enters. When the receiver holds ready low, the beats stay in
// their stages and the pipe fills; ready on the request side falls only
// once all three stages hold a beat.
module barrel_shifter_operand_two import bso_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	bso_req_if.sink   req,
	bso_rsp_if.source rsp
);

	dec_t              dec;
	dec_t              dec_s1;
	rot_t              rot_c;
	rot_t              rot_s2;
	logic [WORD_W-1:0] operand_s3;
	logic              carry_s3;
	logic              vld_s1, vld_s2, vld_s3;
	logic              rdy_s1, rdy_s2, rdy_s3;
	logic [2*WORD_W-1:0] dbl;

	bso_decode u_decode (
		.operand_field  (req.operand_field),
		.imm_form       (req.imm_form),
		.by_register    (req.by_register),
		.reg_value      (req.reg_value),
		.shift_reg_byte (req.shift_reg_byte),
		.carry_in       (req.carry_in),
		.dec            (dec)
	);

	// a stage advances when it is empty or its beat moves on
	assign rdy_s3    = !vld_s3 || rsp.ready;
	assign rdy_s2    = !vld_s2 || rdy_s3;
	assign rdy_s1    = !vld_s1 || rdy_s2;
	assign req.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= req.valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
		end
	end

	// stage 1: register the decoded form
	always_ff @(posedge clk) begin
		if (rdy_s1) dec_s1 <= dec;
	end

	// stage 2 logic: rotate right, build the clear mask, pick the carry
	assign dbl = {dec_s1.val, dec_s1.val} >> dec_s1.rot;

	always_comb begin
		rot_c.rotated = dbl[WORD_W-1:0];
		rot_c.fill    = dec_s1.fill;
		if (dec_s1.clr_hi) begin
			rot_c.mask = ~({WORD_W{1'b1}} >> dec_s1.clr_n);
		end else begin
			rot_c.mask = ~({WORD_W{1'b1}} << dec_s1.clr_n);
		end
		case (dec_s1.csel)
			CSEL_CIN: rot_c.carry = dec_s1.cin;
			CSEL_BIT: rot_c.carry = dec_s1.val[dec_s1.cidx];
			default:  rot_c.carry = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) rot_s2 <= rot_c;
	end

	// stage 3: clear and fill the shifted-out bits
	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			operand_s3 <= (rot_s2.rotated & ~rot_s2.mask) | ({WORD_W{rot_s2.fill}} & rot_s2.mask);
			carry_s3   <= rot_s2.carry;
		end
	end

	assign rsp.valid     = vld_s3;
	assign rsp.operand   = operand_s3;
	assign rsp.carry_out = carry_s3;

	// a stalled stage 2 beat holds
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && !rdy_s3 |=> vld_s2 && $stable(rot_s2))
		else $error("stage 2 beat changed while stalled");

	// a stage 1 beat that moves on lands in stage 2
	a_s1_advance: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && rdy_s2 |=> vld_s2)
		else $error("stage 1 beat lost");

	// clear count never exceeds a word
	a_clr_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> dec_s1.clr_n <= CLR_W'(WORD_W))
		else $error("clear count out of range");

	// a forced-zero carry only comes with a fully cleared, zero-filled operand
	a_zero_carry: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && dec_s1.csel == CSEL_ZERO |-> dec_s1.clr_n == CLR_W'(WORD_W) && !dec_s1.fill)
		else $error("zero carry without zero operand");

endmodule
